// ----- rtl/wfh_pkg.sv -----
// ----------------------------------------------------------------------------
// wfh_pkg
// Shared types and constants of the word fold hash block.
// ----------------------------------------------------------------------------
package wfh_pkg;

    localparam logic [15:0] FOLD_SEED    = 16'h5ab6;
    localparam logic [15:0] BUCKET_RESET = 16'd8191;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FINAL,
        ST_DIV,
        ST_DONE
    } t_state;

    // fold unit control from the sequencer
    typedef struct packed {
        logic take;
        logic clear;
    } t_fold_ctrl;

    // divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ----- rtl/word_fold_hash_mod.sv -----
// ----------------------------------------------------------------------------
// word_fold_hash_mod
// Folds a word into a 16-bit hash and reduces it modulo a nonzero bucket count.
// ----------------------------------------------------------------------------
// input  : i_in_valid / o_in_stall, one transaction per character;
//          i_end_of_word closes the word, with or without a char
// output : o_out_valid / i_out_stall, one bucket_index transaction per word
// config : i_cfg_valid / o_cfg_ready writes bucket_count, only while idle
// a character transaction is accepted in the idle state and back-to-back characters stream
// an end-of-word transaction passes a capture state, the serial remainder
// unit (one bit per cycle) and a done state that hands the result to the
// output reg; with bucket_count zero the division is skipped and the raw
// hash goes from capture straight to the done state
// the input is stalled from capture until the result is in the output reg
// a stalled result holds in the output register while the next word's
// characters keep flowing; a following end-of-word waits in the done state
// until that register frees up
// reset: synchronous, active low; bucket_count returns to 8191, the hash to
// its seed and both channels go empty
// ----------------------------------------------------------------------------
module word_fold_hash_mod #(
    parameter int MAX_WORD_LEN = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input transactions
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_char_byte,
    input  logic        i_has_char,
    input  logic        i_end_of_word,
    // result transactions
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_bucket_index,
    // bucket_count writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_data
);

    wfh_pkg::t_state     r_state, n_state;
    wfh_pkg::t_fold_ctrl fold_ctrl;
    wfh_pkg::t_div_stat  div_stat;

    logic [15:0] r_bucket;
    logic [15:0] r_hash, n_hash;
    logic [15:0] r_out_data, n_out_data;
    logic        r_out_valid, n_out_valid;

    logic        in_accept;
    logic        div_start;
    logic        out_load;
    logic [15:0] fold_hash;
    logic [15:0] div_rem;
    logic [15:0] result;

    assign in_accept = i_in_valid && !o_in_stall;

    wfh_fold #(
        .MAX_WORD_LEN (MAX_WORD_LEN)
    ) u_fold (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (fold_ctrl),
        .i_char_byte (i_char_byte),
        .o_hash      (fold_hash)
    );

    wfh_div u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (fold_hash),
        .i_divisor   (r_bucket),
        .o_stat      (div_stat),
        .o_remainder (div_rem)
    );

    // zero bucket count means no reduction
    assign result = (r_bucket == '0) ? r_hash : div_rem;

    // sequencer state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wfh_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and control
    always_comb begin
        n_state         = r_state;
        n_hash          = r_hash;
        fold_ctrl.take  = 1'b0;
        fold_ctrl.clear = 1'b0;
        div_start       = 1'b0;
        out_load        = 1'b0;
        o_in_stall      = 1'b1;
        unique case (r_state)
            wfh_pkg::ST_IDLE: begin
                // input never stalled here, so valid alone means accepted
                o_in_stall     = 1'b0;
                fold_ctrl.take = i_in_valid && i_has_char;
                if (i_in_valid && i_end_of_word) begin
                    n_state = wfh_pkg::ST_FINAL;
                end
            end
            wfh_pkg::ST_FINAL: begin
                // capture the finished hash and reopen the folder
                n_hash          = fold_hash;
                fold_ctrl.clear = 1'b1;
                if (r_bucket == '0) begin
                    n_state = wfh_pkg::ST_DONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = wfh_pkg::ST_DIV;
                end
            end
            wfh_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    n_state = wfh_pkg::ST_DONE;
                end
            end
            wfh_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = wfh_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wfh_pkg::ST_IDLE;
            end
        endcase
    end

    // output register
    always_comb begin
        n_out_valid = r_out_valid && i_out_stall;
        n_out_data  = r_out_data;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_data  = result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_bucket    <= wfh_pkg::BUCKET_RESET;
        end else begin
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                r_bucket <= i_cfg_data;
            end
        end
        r_out_data <= n_out_data;
        r_hash     <= n_hash;
    end

    assign o_cfg_ready    = (r_state == wfh_pkg::ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_bucket_index = r_out_data;

    // a closing transaction must hold off the next one
    a_eow_stalls: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && i_end_of_word) |=> o_in_stall)
        else $error("input not stalled after end of word");

    // remainder unit only finishes while the sequencer waits on it
    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == wfh_pkg::ST_DIV))
        else $error("division finished outside division state");

    // remainder unit only iterates inside the division state
    a_div_busy_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> (r_state == wfh_pkg::ST_DIV))
        else $error("division running outside division state");

    // a new result only comes out of the done state
    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == wfh_pkg::ST_DONE))
        else $error("result loaded outside done state");

endmodule

// ----- rtl/wfh_fold.sv -----
// ----------------------------------------------------------------------------
// wfh_fold
// Character pair folder: xors little-endian pairs into a 16-bit accumulator.
// ----------------------------------------------------------------------------
module wfh_fold #(
    parameter int MAX_WORD_LEN = 64
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  wfh_pkg::t_fold_ctrl i_ctrl,
    input  logic [7:0]          i_char_byte,
    output logic [15:0]         o_hash
);

    localparam int CW = $clog2(MAX_WORD_LEN + 1);

    logic [15:0]   r_accum, n_accum;
    logic [7:0]    r_low, n_low;
    logic          r_open, n_open;
    logic          r_shift, n_shift;
    logic [CW-1:0] r_count, n_count;

    logic [15:0] pair_val;
    logic [15:0] tail_val;

    always_comb begin
        pair_val = {i_char_byte, r_low};
        if (r_shift) begin
            pair_val = {pair_val[14:0], 1'b0};
        end
    end

    always_comb begin
        n_accum = r_accum;
        n_low   = r_low;
        n_open  = r_open;
        n_shift = r_shift;
        n_count = r_count;
        if (i_ctrl.clear) begin
            n_accum = wfh_pkg::FOLD_SEED;
            n_low   = '0;
            n_open  = 1'b0;
            n_shift = 1'b0;
            n_count = '0;
        end else if (i_ctrl.take && (r_count < CW'(MAX_WORD_LEN))) begin
            n_count = r_count + CW'(1);
            if (!r_open) begin
                n_low  = i_char_byte;
                n_open = 1'b1;
            end else begin
                n_accum = r_accum ^ pair_val;
                n_shift = !r_shift;
                n_open  = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= wfh_pkg::FOLD_SEED;
            r_low   <= '0;
            r_open  <= 1'b0;
            r_shift <= 1'b0;
            r_count <= '0;
        end else begin
            r_accum <= n_accum;
            r_low   <= n_low;
            r_open  <= n_open;
            r_shift <= n_shift;
            r_count <= n_count;
        end
    end

    // odd tail: last char doubled, sign-filled above 0x7f
    assign tail_val = r_low[7] ? {8'hff, r_low} : {r_low, r_low};
    assign o_hash   = r_open ? (r_accum ^ tail_val) : r_accum;

endmodule

// ----- rtl/wfh_div.sv -----
// ----------------------------------------------------------------------------
// wfh_div
// Serial restoring remainder unit, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wfh_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [15:0]        i_dividend,
    input  logic [15:0]        i_divisor,
    output wfh_pkg::t_div_stat o_stat,
    output logic [15:0]        o_remainder
);

    logic [15:0] r_rem, n_rem;
    logic [15:0] r_dvd, n_dvd;
    logic [15:0] r_dsr, n_dsr;
    logic [3:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic        r_done, n_done;

    logic [16:0] trial;

    assign trial = {r_rem, r_dvd[15]};

    always_comb begin
        n_rem  = r_rem;
        n_dvd  = r_dvd;
        n_dsr  = r_dsr;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_rem  = '0;
            n_dvd  = i_dividend;
            n_dsr  = i_divisor;
            n_cnt  = '0;
            n_busy = 1'b1;
        end else if (r_busy) begin
            // remainder < divisor, so trial < 2*divisor and fits after subtract
            if (trial >= {1'b0, r_dsr}) begin
                n_rem = 16'(trial - {1'b0, r_dsr});
            end else begin
                n_rem = trial[15:0];
            end
            n_dvd = {r_dvd[14:0], 1'b0};
            n_cnt = r_cnt + 4'd1;
            if (r_cnt == 4'd15) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_dvd <= n_dvd;
        r_dsr <= n_dsr;
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_remainder = r_rem;

endmodule
